### hw/rtl/lpm_pkg.sv
package lpm_pkg;

    localparam int unsigned DEF_PEAK_BUCKETS = 6;

    // reset values of the configuration registers
    localparam logic [31:0] DEF_WINDOW_US = 32'd1000000;
    localparam logic [31:0] DEF_BUCKET_US = 32'd10000000;
    localparam logic [31:0] DEF_SLOW_US   = 32'd100000;

    // register indexes on the configuration port
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_BUCKET = 2'd1;
    localparam logic [1:0] REG_SLOW   = 2'd2;

    // rate = ticks * RATE_SCALE / elapsed; the product fits in 32 + 20 bits
    localparam int unsigned SCALE_W  = 20;
    localparam logic [SCALE_W-1:0] RATE_SCALE = 20'd1000000;
    localparam int unsigned NUM_W    = 32 + SCALE_W;
    localparam int unsigned DCNT_W   = $clog2(NUM_W);

    localparam logic [2:0] SLOW_MAX  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PEAK,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } lpm_state_t;

endpackage

### hw/rtl/loop_period_monitor.sv
// Loop period monitor. Each request on the slave stream carries one loop-tick
// timestamp in microseconds; each produces exactly one result on the master
// stream with the tick delta, the last window rate in Hz, the peak delta over
// the bucket ring, the slow-bucket count and the all-time maximum delta. The
// first tick after reset only sets the time origins and is flagged in tuser.
// A measured tick passes through the load, peak and scan states, and also
// through the divide state when it closes a rate window (the restoring
// divider produces one quotient bit per cycle for a 52-bit dividend, then
// hands the quotient back). The first tick after reset goes from load
// straight to the scan. A finished result waits in the done state while the
// output register is full and not drained. The bucket ring sits in a small
// memory read once per bucket during the peak scan. A new request is taken
// whenever the sequencer is idle, even while the previous result still
// waits on the master side.
module loop_period_monitor
    import lpm_pkg::*;
#(
    parameter int unsigned PEAK_BUCKETS = DEF_PEAK_BUCKETS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // timestamp_us[62:0], zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // loop_delta_us[31:0], loop_rate_hz[63:32],
                                         // recent_peak_us[95:64],
                                         // slow_bucket_count[98:96],
                                         // max_delta_ever_us[130:99], zero pad
    output logic [1:0]   m_axis_tuser,   // first_tick[0], rate_updated[1]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned AW = $clog2(PEAK_BUCKETS);
    localparam int unsigned SW = $clog2(PEAK_BUCKETS + 1);

    lpm_state_t state_reg, state_next;

    logic [31:0] window_len_reg;
    logic [31:0] bucket_len_reg;
    logic [31:0] slow_thr_reg;

    logic        started_reg;
    logic [31:0] now_reg;
    logic [31:0] last_reg;
    logic [31:0] win_start_reg;
    logic [31:0] bkt_start_reg;
    logic [31:0] tick_cnt_reg;
    logic [31:0] rate_reg;
    logic [31:0] max_reg;
    logic [AW-1:0] ptr_reg;
    logic [31:0] delta_reg;
    logic        first_reg;
    logic        updated_reg;
    logic        rotated_reg;
    logic [SW-1:0] scan_reg;
    logic [31:0] peak_reg;
    logic [2:0]  slow_reg;

    logic         out_valid_reg;
    logic [130:0] out_data_reg;
    logic [1:0]   out_user_reg;

    logic [31:0] delta_now;
    logic [31:0] bkt_elapsed;
    logic        rotate;
    logic [AW-1:0] ptr_new;
    logic [31:0] win_elapsed;
    logic        win_close;

    logic        accept;
    logic        out_load;
    logic        scan_end;

    logic          bkt_we;
    logic [AW-1:0] bkt_raddr;
    logic [31:0]   bkt_rdata;
    logic [31:0]   bkt_wdata;

    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_quot;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign scan_end = (scan_reg == SW'(PEAK_BUCKETS));

    // only the low 32 bits of any time difference are ever used
    always_comb
    begin
        delta_now   = now_reg - last_reg;
        bkt_elapsed = now_reg - bkt_start_reg;
        rotate      = (bkt_elapsed >= bucket_len_reg);
        if (!rotate)
            ptr_new = ptr_reg;
        else if (ptr_reg == AW'(PEAK_BUCKETS - 1))
            ptr_new = '0;
        else
            ptr_new = ptr_reg + 1'b1;
        win_elapsed = now_reg - win_start_reg;
        win_close   = (win_elapsed >= window_len_reg) && (win_elapsed != '0);
        div_num     = NUM_W'(tick_cnt_reg) * NUM_W'(RATE_SCALE);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = started_reg ? ST_PEAK : ST_SCAN;
            ST_PEAK:
                state_next = win_close ? ST_DIV : ST_SCAN;
            ST_DIV:
                if (div_done)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (scan_end)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        bkt_we        = 1'b0;
        div_start     = 1'b0;
        bkt_raddr     = scan_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_LOAD:
                bkt_raddr = ptr_new;
            ST_PEAK:
            begin
                bkt_we    = 1'b1;
                div_start = win_close;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // a freshly rotated bucket counts as zero, so the delta goes in as is
    assign bkt_wdata = (rotated_reg || delta_reg > bkt_rdata) ? delta_reg : bkt_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= DEF_WINDOW_US;
            bucket_len_reg <= DEF_BUCKET_US;
            slow_thr_reg   <= DEF_SLOW_US;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW: window_len_reg <= cfg_data;
                REG_BUCKET: bucket_len_reg <= cfg_data;
                REG_SLOW:   slow_thr_reg   <= cfg_data;
                default:    window_len_reg <= window_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            last_reg      <= '0;
            win_start_reg <= '0;
            bkt_start_reg <= '0;
            tick_cnt_reg  <= '0;
            rate_reg      <= '0;
            max_reg       <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            if (state_reg == ST_LOAD)
            begin
                last_reg <= now_reg;
                if (!started_reg)
                begin
                    started_reg   <= 1'b1;
                    win_start_reg <= now_reg;
                    bkt_start_reg <= now_reg;
                end
                else
                begin
                    tick_cnt_reg <= tick_cnt_reg + 1'b1;
                    if (delta_now > max_reg)
                        max_reg <= delta_now;
                    ptr_reg <= ptr_new;
                    if (rotate)
                        bkt_start_reg <= now_reg;
                end
            end
            if (state_reg == ST_DIV && div_done)
            begin
                rate_reg      <= div_quot[31:0];
                win_start_reg <= now_reg;
                tick_cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            now_reg <= s_axis_tdata[31:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                first_reg   <= !started_reg;
                delta_reg   <= started_reg ? delta_now : '0;
                rotated_reg <= rotate;
                updated_reg <= 1'b0;
                scan_reg    <= '0;
                peak_reg    <= '0;
                slow_reg    <= '0;
            end
            ST_DIV:
                if (div_done)
                    updated_reg <= 1'b1;
            ST_SCAN:
            begin
                // read data arrives in the cycle after its address
                if (scan_reg != '0)
                begin
                    if (bkt_rdata > peak_reg)
                        peak_reg <= bkt_rdata;
                    if (bkt_rdata >= slow_thr_reg && slow_reg != SLOW_MAX)
                        slow_reg <= slow_reg + 1'b1;
                end
                if (!scan_end)
                    scan_reg <= scan_reg + 1'b1;
            end
            default:
                peak_reg <= peak_reg;
        endcase
        if (out_load)
        begin
            out_data_reg <= {max_reg, slow_reg, peak_reg, rate_reg, delta_reg};
            out_user_reg <= {updated_reg, first_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};
    assign m_axis_tuser  = out_user_reg;

    lpm_bucket #(
        .PEAK_BUCKETS (PEAK_BUCKETS)
    ) u_bucket (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (bkt_we),
        .waddr (ptr_reg),
        .wdata (bkt_wdata),
        .raddr (bkt_raddr),
        .rdata (bkt_rdata)
    );

    lpm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (div_num),
        .divisor   (win_elapsed),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot)
    );

`ifndef NO_ASSERTIONS
    a_no_first_update: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("first tick reported a rate update");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOAD)
        else $error("accepted request did not start the sequencer");

    a_slow_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[98:96]) <= PEAK_BUCKETS))
        else $error("slow bucket count exceeds bucket count");
`endif

endmodule

### hw/rtl/lpm_div.sv
module lpm_div
    import lpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [31:0]      divisor,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic [NUM_W-1:0]  num_reg;
    logic [31:0]       rem_reg;
    logic [31:0]       dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [32:0]       rem_shift;
    logic              fits;
    logic [32:0]       rem_sub;

    // one restoring step per cycle, quotient bits shift in behind the numerator
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        rem_sub   = rem_shift - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg <= numerator;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub[31:0] : rem_shift[31:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

### hw/rtl/lpm_bucket.sv
module lpm_bucket
    import lpm_pkg::*;
#(
    parameter int unsigned PEAK_BUCKETS = DEF_PEAK_BUCKETS,
    localparam int unsigned AW = $clog2(PEAK_BUCKETS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0]             mem [PEAK_BUCKETS];
    logic [PEAK_BUCKETS-1:0] valid_reg;
    logic [31:0]             rdata_reg;
    logic                    rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // an entry never written since reset reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule
